// File: hw/rtl/salru_pkg.sv
// salru_pkg: shared types, codes and defaults for the LRU tag-store core
// no dependencies; imported by every module of the block but salru_ram
`default_nettype none

package salru_pkg;

  // build-time defaults for the top-level parameters
  localparam int DEF_MAX_SET_BITS = 4;
  localparam int DEF_MAX_WAYS     = 4;

  // fixed field widths
  localparam int ADDR_W      = 64;
  localparam int TAG_W       = 64;
  localparam int STAMP_W     = 64;
  localparam int COUNT_W     = 32;
  localparam int SET_OUT_W   = 4;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int QUEUE_DEPTH = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  // configuration registers as seen by front and back
  typedef struct packed {
    logic [2:0] set_bits;
    logic [5:0] block_bits;
    logic [2:0] ways_in_use;
  } cfg_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_UPDATE
  } bk_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/salru_ram.sv
// salru_ram: generic single-write, single-read RAM with registered read
// no dependencies
`default_nettype none

module salru_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/salru_front.sv
// salru_front: accepts requests, derives set and tag, splits modify in two
// depends on salru_pkg
`default_nettype none

module salru_front #(
  parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
  parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire salru_pkg::cfg_t                    cfg,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [salru_pkg::OP_W-1:0]         operation,
  input  wire logic [salru_pkg::ADDR_W-1:0]       address,
  output logic                                    push_valid,
  input  wire logic                               push_ready,
  output logic [SET_W+salru_pkg::TAG_W:0]         push_data
);

  import salru_pkg::*;

  logic             hold_valid;
  logic             hold_two;
  logic [SET_W-1:0] hold_set;
  logic [TAG_W-1:0] hold_tag;

  logic [3:0]        sb_c;
  logic [6:0]        tag_shift;
  logic [SET_W-1:0]  set_mask;
  logic [ADDR_W-1:0] offset_shifted;
  logic [SET_W-1:0]  set_calc;
  logic [TAG_W-1:0]  tag_calc;
  logic              accept;
  logic              is_access;

  // set and tag from the address under the current configuration
  always_comb begin
    sb_c = (4'(cfg.set_bits) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(cfg.set_bits);
    tag_shift = 7'(sb_c) + 7'(cfg.block_bits);
    set_mask = ~({SET_W{1'b1}} << sb_c);
    offset_shifted = address >> cfg.block_bits;
    set_calc = offset_shifted[SET_W-1:0] & set_mask;
    tag_calc = (tag_shift >= 7'd64) ? '0 : (address >> tag_shift[5:0]);
  end

  // one request held at a time; unknown codes are taken and dropped
  assign in_stall  = hold_valid;
  assign accept    = in_valid && !in_stall;
  assign is_access = (operation == OP_LOAD) || (operation == OP_STORE) ||
                     (operation == OP_MODIFY);

  assign push_valid = hold_valid;
  assign push_data  = {hold_set, hold_tag, !hold_two};

  // hold stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_two   <= 1'b0;
    end else if (accept) begin
      hold_valid <= is_access;
      hold_two   <= (operation == OP_MODIFY);
    end else if (hold_valid && push_ready) begin
      if (hold_two) begin
        hold_two <= 1'b0;
      end else begin
        hold_valid <= 1'b0;
      end
    end
  end

  // hold stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_set <= set_calc;
      hold_tag <= tag_calc;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/salru_queue.sv
// salru_queue: short FIFO of pending accesses between front and back
// depends on salru_pkg
`default_nettype none

module salru_queue #(
  parameter int WIDTH = 69
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data
);

  import salru_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/salru_back.sv
// salru_back: per-access sequencer; scans one way per cycle, updates lru state
// depends on salru_pkg and salru_ram
`default_nettype none

module salru_back #(
  parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS,
  parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire salru_pkg::cfg_t                     cfg,
  input  wire logic                                q_valid,
  output logic                                     q_pop,
  input  wire logic [SET_W+salru_pkg::TAG_W:0]     q_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     hit,
  output logic                                     evicted,
  output logic [salru_pkg::SET_OUT_W-1:0]          set_index,
  output logic [salru_pkg::COUNT_W-1:0]            total_hits,
  output logic [salru_pkg::COUNT_W-1:0]            total_misses,
  output logic [salru_pkg::COUNT_W-1:0]            total_evictions,
  output logic                                     last
);

  import salru_pkg::*;

  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W    = SET_W + WAY_W;
  localparam int NUM_LINES = 1 << LINE_W;

  bk_state_t state, state_next;

  logic [SET_W-1:0]   q_set;
  logic [TAG_W-1:0]   q_tag;
  logic               q_last;

  logic [SET_W-1:0]   cur_set;
  logic [TAG_W-1:0]   cur_tag;
  logic               cur_last;
  logic [WAY_W-1:0]   cmp_way;
  logic               hit_r;
  logic [WAY_W-1:0]   hit_way;
  logic               empty_found;
  logic [WAY_W-1:0]   empty_way;
  logic [WAY_W-1:0]   victim_way;
  logic [STAMP_W-1:0] victim_stamp;
  logic [STAMP_W-1:0] access_clock;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] miss_count;
  logic [COUNT_W-1:0] evict_count;
  logic [LINE_W-1:0]  clr_line;

  logic               clear;
  logic               start;
  logic               scan;
  logic               update;
  logic [LINE_W-1:0]  rd_line;
  logic [LINE_W-1:0]  wr_line;
  logic               tag_we;
  logic [LINE_W-1:0]  tag_waddr;
  logic [TAG_W:0]     tag_wdata;
  logic [TAG_W:0]     tag_rd;
  logic               line_valid_rd;
  logic [STAMP_W-1:0] stamp_rd;
  logic               line_hit;
  logic [4:0]         ways_c;
  logic [WAY_W-1:0]   last_way;
  logic [WAY_W-1:0]   wr_way;
  logic               evict_now;
  logic [COUNT_W-1:0] hit_count_next;
  logic [COUNT_W-1:0] miss_count_next;
  logic [COUNT_W-1:0] evict_count_next;

  assign {q_set, q_tag, q_last} = q_data;

  // ways in use clamped to 1..MAX_WAYS
  always_comb begin
    ways_c = 5'(cfg.ways_in_use);
    if (ways_c == 5'd0) begin
      ways_c = 5'd1;
    end else if (ways_c > 5'(MAX_WAYS)) begin
      ways_c = 5'(MAX_WAYS);
    end
    last_way = WAY_W'(ways_c - 5'd1);
  end

  // compare of the way whose read came back this cycle
  assign line_valid_rd = tag_rd[TAG_W];
  assign line_hit      = line_valid_rd && (tag_rd[TAG_W-1:0] == cur_tag);

  // sequencer next state and strobes
  always_comb begin
    state_next = state;
    clear      = 1'b0;
    start      = 1'b0;
    scan       = 1'b0;
    update     = 1'b0;
    rd_line    = {cur_set, WAY_W'(cmp_way + 1'b1)};
    case (state)
      BK_CLEAR: begin
        clear = 1'b1;
        if (clr_line == LINE_W'(NUM_LINES - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        rd_line = {q_set, {WAY_W{1'b0}}};
        if (q_valid && (!out_valid || !out_stall)) begin
          start      = 1'b1;
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        scan = 1'b1;
        if (line_hit || (cmp_way == last_way)) begin
          state_next = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        update     = 1'b1;
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign q_pop = start;

  // line chosen for the update and the new totals
  always_comb begin
    wr_way    = hit_r ? hit_way : (empty_found ? empty_way : victim_way);
    wr_line   = {cur_set, wr_way};
    evict_now = !hit_r && !empty_found;
    hit_count_next   = hit_count;
    miss_count_next  = miss_count;
    evict_count_next = evict_count;
    if (hit_r) begin
      hit_count_next = (hit_count == '1) ? hit_count : hit_count + 1'b1;
    end else begin
      miss_count_next = (miss_count == '1) ? miss_count : miss_count + 1'b1;
    end
    if (evict_now) begin
      evict_count_next = (evict_count == '1) ? evict_count : evict_count + 1'b1;
    end
  end

  // valid bit and tag write: clearing pass after reset, fill on a miss
  always_comb begin
    tag_we    = clear || (update && !hit_r);
    tag_waddr = clear ? clr_line : wr_line;
    tag_wdata = clear ? '0 : {1'b1, cur_tag};
  end

  // valid-and-tag and timestamp stores
  salru_ram #(
    .WIDTH (TAG_W + 1),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (rd_line),
    .rdata (tag_rd)
  );

  salru_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (NUM_LINES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (update),
    .waddr (wr_line),
    .wdata (access_clock),
    .raddr (rd_line),
    .rdata (stamp_rd)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clock, totals, clearing counter and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock <= '0;
      hit_count    <= '0;
      miss_count   <= '0;
      evict_count  <= '0;
      clr_line     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (clear) begin
        clr_line <= clr_line + 1'b1;
      end
      if (start) begin
        access_clock <= access_clock + 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (update) begin
        hit_count   <= hit_count_next;
        miss_count  <= miss_count_next;
        evict_count <= evict_count_next;
        out_valid   <= 1'b1;
      end
    end
  end

  // per-access scan registers and result payload
  always_ff @(posedge clk) begin
    if (start) begin
      cur_set     <= q_set;
      cur_tag     <= q_tag;
      cur_last    <= q_last;
      cmp_way     <= '0;
      hit_r       <= 1'b0;
      empty_found <= 1'b0;
    end
    if (scan) begin
      if (line_hit) begin
        hit_r   <= 1'b1;
        hit_way <= cmp_way;
      end else begin
        if (!line_valid_rd && !empty_found) begin
          empty_found <= 1'b1;
          empty_way   <= cmp_way;
        end
        if ((cmp_way == '0) || (stamp_rd < victim_stamp)) begin
          victim_way   <= cmp_way;
          victim_stamp <= stamp_rd;
        end
        if (cmp_way != last_way) begin
          cmp_way <= cmp_way + 1'b1;
        end
      end
    end
    if (update) begin
      hit             <= hit_r;
      evicted         <= evict_now;
      set_index       <= SET_OUT_W'(cur_set);
      total_hits      <= hit_count_next;
      total_misses    <= miss_count_next;
      total_evictions <= evict_count_next;
      last            <= cur_last;
    end
  end

  // the result slot is free whenever an update is about to load it
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == BK_UPDATE) |-> !out_valid)
    else $error("result slot busy at update");

  // an update always presents a result next cycle
  a_update_out: assert property (@(posedge clk) disable iff (rst)
    (state == BK_UPDATE) |=> (out_valid && (state == BK_IDLE)))
    else $error("update did not present a result");

  // the scan never passes the last way in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN) |-> (cmp_way <= last_way))
    else $error("scan past last way");

  // a hit and an eviction never come together
  a_hit_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit reported with eviction");

endmodule

`default_nettype wire

// File: hw/rtl/set_assoc_lru_cache_sim_core.sv
// set_assoc_lru_cache_sim_core: top level of the LRU tag-store core
// depends on salru_pkg, salru_front, salru_queue, salru_back, salru_ram
//
//   channel   | handshake           | payload
//   ----------+---------------------+--------------------------------------------
//   request   | in_valid / in_stall | operation, address
//   result    | out_valid/out_stall | hit, evicted, set_index, total_*, last
//   config    | cfg_write           | cfg_index, cfg_data
//
// each access passes through the back end as a start, a scan that compares one way
// per cycle through the tag and stamp RAM read port, and one update;
// a hit ends the scan early. modify makes two accesses
// the front holds one request and hands its accesses through a two-entry queue
// reset clears the clock and the totals at once; the back end then clears the
// valid bits one line per cycle (64 lines by default) before its first access
// a stalled result holds its register; the back end starts the next access only
// once the result register is free or being taken
`default_nettype none

module set_assoc_lru_cache_sim_core #(
  parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [salru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [salru_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [salru_pkg::OP_W-1:0]           operation,
  input  wire logic [salru_pkg::ADDR_W-1:0]         address,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      hit,
  output logic                                      evicted,
  output logic [salru_pkg::SET_OUT_W-1:0]           set_index,
  output logic [salru_pkg::COUNT_W-1:0]             total_hits,
  output logic [salru_pkg::COUNT_W-1:0]             total_misses,
  output logic [salru_pkg::COUNT_W-1:0]             total_evictions,
  output logic                                      last
);

  import salru_pkg::*;

  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ENTRY_W = SET_W + TAG_W + 1;

  cfg_t               cfg;
  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               q_valid;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits    <= 3'd0;
      cfg.block_bits  <= 6'd0;
      cfg.ways_in_use <= 3'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SET_BITS:    cfg.set_bits    <= cfg_data[2:0];
        REG_BLOCK_BITS:  cfg.block_bits  <= cfg_data[5:0];
        REG_WAYS_IN_USE: cfg.ways_in_use <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // request intake
  salru_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .SET_W        (SET_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .address    (address),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // pending access queue
  salru_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // lookup, replacement and results
  salru_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .SET_W        (SET_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_data          (q_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .evicted         (evicted),
    .set_index       (set_index),
    .total_hits      (total_hits),
    .total_misses    (total_misses),
    .total_evictions (total_evictions),
    .last            (last)
  );

endmodule

`default_nettype wire
